### hdl/fla_pkg.sv
// Shared constants, codes and control types of the free-list allocator.
package fla_pkg;

   // Arena geometry
   localparam int ARENA_BYTES = 4096;
   localparam int ADDR_W      = $clog2(ARENA_BYTES);
   localparam int LINK_W      = ADDR_W + 1;
   localparam int REAL_W      = LINK_W + 1;
   localparam int WALK_LIMIT  = 2 * ARENA_BYTES;
   localparam int STEP_W      = $clog2(WALK_LIMIT + 1);

   localparam logic [LINK_W-1:0] NIL_LINK       = LINK_W'(ARENA_BYTES);
   localparam logic [LINK_W-1:0] MIN_PAYLOAD    = LINK_W'(12);
   localparam logic [LINK_W-1:0] BUSY_HDR       = LINK_W'(4);
   localparam logic [REAL_W-1:0] MIN_FREE_BLOCK = REAL_W'(16);
   localparam logic [STEP_W-1:0] STEP_MAX       = STEP_W'(WALK_LIMIT);

   // Fit policy codes
   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   // Opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_A_RD, S_A_EV, S_A_PRD, S_A_PEV, S_A_SPLIT, S_A_COMMIT,
      S_F_HDR, S_F_RD, S_F_EV, S_F_LINK2,
      S_M_INIT, S_M_RD, S_M_EV, S_M_EV2,
      S_DONE
   } fla_state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_CLEAR, CMD_ACCEPT,
      CMD_A_RD, CMD_A_EV, CMD_A_PRD, CMD_A_PEV, CMD_A_SPLIT, CMD_A_COMMIT,
      CMD_F_HDR, CMD_F_RD, CMD_F_EV, CMD_F_LINK2,
      CMD_M_INIT, CMD_M_RD, CMD_M_EV, CMD_M_EV2,
      CMD_LOAD
   } fla_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic in_alloc;
      logic in_off_ok;
      logic walk_ok;
      logic first_stop;
      logic pick_node;
      logic split;
      logic list_empty;
      logic head_gt;
      logic f_walk;
      logic ins;
      logic touch;
      logic rsp_busy;
   } fla_status_type;

endpackage

### hdl/free_list_allocator_unit.sv
// Top level of the free-list allocator: stream ports, controller and datapath.
// Byte arena allocator with an address-ordered free list kept in two header
// memories (block size and next link, one entry per byte offset). After reset a
// clearing pass over every entry initializes the memories; no item is taken then.
// An allocate walks the free list node by node (first fit stops at the first
// fitting node, best and worst fit walk the whole list); a free walks the list
// to find its place, then makes a merge pass over the list, absorbing each
// touching neighbor. Every node visited costs a read through the single read
// port of the header memories. A finished result waits in an output register
// while the next item is taken.
module free_list_allocator_unit
   import fla_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [12:0] request_bytes, [24:13] release_offset
   input  logic        req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [0] success, [12:1] grant_offset, [25:13] grant_bytes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data     // fit_policy
);

   fla_cmd_type       cmd;
   fla_status_type    status;
   logic              rsp_success;
   logic [ADDR_W-1:0] rsp_grant_offset;
   logic [LINK_W-1:0] rsp_grant_bytes;

   // policy register is always writable
   assign csr_ready = 1'b1;

   fla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd),
      .req_tready (req_tready)
   );

   fla_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .in_opcode         (req_tuser),
      .in_request_bytes  (req_tdata[12:0]),
      .in_release_offset (req_tdata[24:13]),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_success       (rsp_success),
      .rsp_grant_offset  (rsp_grant_offset),
      .rsp_grant_bytes   (rsp_grant_bytes),
      .status            (status)
   );

   // pack the result item
   assign rsp_tdata = {6'd0, rsp_grant_bytes, rsp_grant_offset, rsp_success};

endmodule

### hdl/fla_ctrl.sv
// Controller state machine of the free-list allocator.
module fla_ctrl
   import fla_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  fla_status_type status,
   output fla_cmd_type    cmd,
   output logic           req_tready
);

   fla_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               if (status.in_alloc)       state_in = S_A_RD;
               else if (status.in_off_ok) state_in = S_F_HDR;
               else                       state_in = S_DONE;
            end
         end
         S_A_RD:     state_in = status.walk_ok ? S_A_EV : S_A_PRD;
         S_A_EV:     state_in = status.first_stop ? S_A_PRD : S_A_RD;
         S_A_PRD:    state_in = status.pick_node ? S_A_PEV : S_DONE;
         S_A_PEV:    state_in = status.split ? S_A_SPLIT : S_A_COMMIT;
         S_A_SPLIT:  state_in = S_A_COMMIT;
         S_A_COMMIT: state_in = S_DONE;
         S_F_HDR: begin
            state_in = (status.list_empty || status.head_gt) ? S_M_INIT : S_F_RD;
         end
         S_F_RD:     state_in = status.f_walk ? S_F_EV : S_M_INIT;
         S_F_EV:     state_in = status.ins ? S_F_LINK2 : S_F_RD;
         S_F_LINK2:  state_in = S_M_INIT;
         S_M_INIT:   state_in = S_M_RD;
         S_M_RD:     state_in = status.walk_ok ? S_M_EV : S_DONE;
         S_M_EV:     state_in = status.touch ? S_M_EV2 : S_M_RD;
         S_M_EV2:    state_in = S_M_RD;
         S_DONE: begin
            if (!status.rsp_busy) state_in = S_IDLE;
         end
         default:    state_in = S_CLEAR;
      endcase
   end

   // commands
   always_comb begin
      req_tready = 1'b0;
      cmd        = CMD_NONE;
      unique case (state_ff)
         S_CLEAR:    cmd = CMD_CLEAR;
         S_IDLE: begin
            req_tready = 1'b1;
            cmd        = req_tvalid ? CMD_ACCEPT : CMD_NONE;
         end
         S_A_RD:     cmd = CMD_A_RD;
         S_A_EV:     cmd = CMD_A_EV;
         S_A_PRD:    cmd = CMD_A_PRD;
         S_A_PEV:    cmd = CMD_A_PEV;
         S_A_SPLIT:  cmd = CMD_A_SPLIT;
         S_A_COMMIT: cmd = CMD_A_COMMIT;
         S_F_HDR:    cmd = CMD_F_HDR;
         S_F_RD:     cmd = CMD_F_RD;
         S_F_EV:     cmd = CMD_F_EV;
         S_F_LINK2:  cmd = CMD_F_LINK2;
         S_M_INIT:   cmd = CMD_M_INIT;
         S_M_RD:     cmd = CMD_M_RD;
         S_M_EV:     cmd = CMD_M_EV;
         S_M_EV2:    cmd = CMD_M_EV2;
         S_DONE:     cmd = status.rsp_busy ? CMD_NONE : CMD_LOAD;
         default:    cmd = CMD_NONE;
      endcase
   end

   // a first-fit walk never continues past a fitting block
   a_first_stop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_EV && status.first_stop) |=> state_ff == S_A_PRD)
      else $error("first fit walk went on after a hit");

   // a request is only taken once the clearing pass is over
   a_clear_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && !status.clr_done) |=> !req_tready)
      else $error("item taken during clearing pass");

   // the result stage is never overwritten while it is stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      status.rsp_busy |-> cmd != CMD_LOAD)
      else $error("result loaded over a stalled item");

endmodule

### hdl/fla_datapath.sv
// Datapath of the free-list allocator: header memories, walk registers, result stage.
module fla_datapath
   import fla_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  fla_cmd_type         cmd,
   input  logic                in_opcode,
   input  logic [LINK_W-1:0]   in_request_bytes,
   input  logic [ADDR_W-1:0]   in_release_offset,
   input  logic                csr_valid,
   input  logic [1:0]          csr_data,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic                rsp_success,
   output logic [ADDR_W-1:0]   rsp_grant_offset,
   output logic [LINK_W-1:0]   rsp_grant_bytes,
   output fla_status_type      status
);

   // header memories: block size and next-free link per byte offset
   logic [LINK_W-1:0] size_ram [ARENA_BYTES];
   logic [LINK_W-1:0] next_ram [ARENA_BYTES];

   logic              size_we, next_we, rd_en;
   logic [ADDR_W-1:0] size_wa, next_wa, rd_addr;
   logic [LINK_W-1:0] size_wd, next_wd;
   logic [LINK_W-1:0] rd_size_ff, rd_next_ff;

   // control state
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [1:0]        policy_ff;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic              empty_ff, empty_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              rsp_valid_ff;

   // walk registers
   logic [LINK_W-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [LINK_W-1:0] pick_ff, pick_in, pick_prev_ff, pick_prev_in;
   logic [LINK_W-1:0] cand_ff, cand_in, gsize_ff, gsize_in;
   logic [LINK_W-1:0] sav_ff, sav_in, csz_ff, csz_in;
   logic [REAL_W-1:0] real_ff, real_in;
   logic [ADDR_W-1:0] hdr_ff, hdr_in;
   logic              split_ff, split_in;

   // result registers
   logic              res_success_ff, res_success_in;
   logic [ADDR_W-1:0] res_off_ff, res_off_in;
   logic [LINK_W-1:0] res_bytes_ff, res_bytes_in;
   logic              out_success_ff;
   logic [ADDR_W-1:0] out_off_ff;
   logic [LINK_W-1:0] out_bytes_ff;

   // helpers
   logic [LINK_W-1:0] head_node, req_size, nb_link, target;
   logic [REAL_W-1:0] rest_w, end_w, touch_sum;
   logic              hit, cur_node, nx_node, whole;

   assign head_node = empty_ff ? NIL_LINK : {1'b0, head_ff};
   assign req_size  = (in_request_bytes < MIN_PAYLOAD) ? MIN_PAYLOAD : in_request_bytes;
   assign cur_node  = cur_ff < NIL_LINK;
   assign nx_node   = rd_next_ff < NIL_LINK;
   assign hit       = {1'b0, rd_size_ff} >= real_ff;
   assign rest_w    = {1'b0, rd_size_ff} - real_ff;
   assign end_w     = {1'b0, pick_ff} + real_ff;
   assign whole     = (rest_w < MIN_FREE_BLOCK) || (end_w >= REAL_W'(ARENA_BYTES));
   assign nb_link   = end_w[LINK_W-1:0];
   assign target    = split_ff ? nb_link : sav_ff;
   assign touch_sum = {1'b0, cur_ff} + {1'b0, rd_size_ff};

   // status to the controller
   always_comb begin
      status.clr_done   = clr_cnt_ff == ADDR_W'(ARENA_BYTES - 1);
      status.in_alloc   = in_opcode == OP_ALLOC;
      status.in_off_ok  = in_release_offset >= BUSY_HDR[ADDR_W-1:0];
      status.walk_ok    = cur_node && (steps_ff != STEP_MAX);
      status.first_stop = hit && (policy_ff != POL_BEST) && (policy_ff != POL_WORST);
      status.pick_node  = pick_ff < NIL_LINK;
      status.split      = !whole;
      status.list_empty = empty_ff;
      status.head_gt    = head_ff > hdr_ff;
      status.f_walk     = cur_node && (cur_ff[ADDR_W-1:0] < hdr_ff) && (steps_ff != STEP_MAX);
      status.ins        = !nx_node || (rd_next_ff[ADDR_W-1:0] > hdr_ff);
      status.touch      = nx_node && ({1'b0, rd_next_ff} == touch_sum);
      status.rsp_busy   = rsp_valid_ff && !rsp_tready;
   end

   // command decode: next values and memory accesses
   always_comb begin
      clr_cnt_in     = clr_cnt_ff;
      head_in        = head_ff;
      empty_in       = empty_ff;
      steps_in       = steps_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      pick_in        = pick_ff;
      pick_prev_in   = pick_prev_ff;
      cand_in        = cand_ff;
      gsize_in       = gsize_ff;
      sav_in         = sav_ff;
      csz_in         = csz_ff;
      real_in        = real_ff;
      hdr_in         = hdr_ff;
      split_in       = split_ff;
      res_success_in = res_success_ff;
      res_off_in     = res_off_ff;
      res_bytes_in   = res_bytes_ff;
      size_we = 1'b0;  size_wa = cur_ff[ADDR_W-1:0];  size_wd = '0;
      next_we = 1'b0;  next_wa = cur_ff[ADDR_W-1:0];  next_wd = '0;
      rd_en   = 1'b0;  rd_addr = cur_ff[ADDR_W-1:0];
      unique case (cmd)
         CMD_NONE, CMD_LOAD: begin
         end
         CMD_CLEAR: begin
            // entry zero holds the whole arena, all others zero
            size_we    = 1'b1;
            next_we    = 1'b1;
            size_wa    = clr_cnt_ff;
            next_wa    = clr_cnt_ff;
            size_wd    = (clr_cnt_ff == '0) ? NIL_LINK : '0;
            next_wd    = (clr_cnt_ff == '0) ? NIL_LINK : '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         CMD_ACCEPT: begin
            res_success_in = 1'b0;
            res_off_in     = '0;
            res_bytes_in   = '0;
            steps_in       = '0;
            if (in_opcode == OP_ALLOC) begin
               gsize_in     = req_size;
               real_in      = {1'b0, req_size} + {1'b0, BUSY_HDR};
               cur_in       = head_node;
               prev_in      = NIL_LINK;
               pick_in      = NIL_LINK;
               pick_prev_in = NIL_LINK;
               cand_in      = (policy_ff == POL_BEST) ? NIL_LINK : LINK_W'(1);
            end else begin
               hdr_in         = in_release_offset - BUSY_HDR[ADDR_W-1:0];
               res_success_in = in_release_offset >= BUSY_HDR[ADDR_W-1:0];
               rd_en          = 1'b1;
               rd_addr        = in_release_offset - BUSY_HDR[ADDR_W-1:0];
            end
         end
         CMD_A_RD, CMD_F_RD, CMD_M_RD: begin
            rd_en = 1'b1;
         end
         CMD_A_EV: begin
            steps_in = steps_ff + 1'b1;
            if (policy_ff == POL_BEST) begin
               if (hit && rd_size_ff <= cand_ff) begin
                  pick_in = cur_ff;  pick_prev_in = prev_ff;  cand_in = rd_size_ff;
               end
            end else if (policy_ff == POL_WORST) begin
               if (hit && rd_size_ff >= cand_ff) begin
                  pick_in = cur_ff;  pick_prev_in = prev_ff;  cand_in = rd_size_ff;
               end
            end else if (hit) begin
               pick_in = cur_ff;  pick_prev_in = prev_ff;
            end
            prev_in = cur_ff;
            cur_in  = rd_next_ff;
         end
         CMD_A_PRD: begin
            rd_en   = 1'b1;
            rd_addr = pick_ff[ADDR_W-1:0];
         end
         CMD_A_PEV: begin
            split_in = !whole;
            if (whole) gsize_in = rd_size_ff - BUSY_HDR;
            sav_in = rd_next_ff;
            csz_in = rest_w[LINK_W-1:0];
         end
         CMD_A_SPLIT: begin
            // leftover becomes a new free node after the granted part
            size_we = 1'b1;  size_wa = nb_link[ADDR_W-1:0];  size_wd = csz_ff;
            next_we = 1'b1;  next_wa = nb_link[ADDR_W-1:0];  next_wd = sav_ff;
         end
         CMD_A_COMMIT: begin
            size_we = 1'b1;  size_wa = pick_ff[ADDR_W-1:0];  size_wd = gsize_ff;
            if (pick_prev_ff < NIL_LINK) begin
               next_we = 1'b1;  next_wa = pick_prev_ff[ADDR_W-1:0];  next_wd = target;
            end else if (target < NIL_LINK) begin
               head_in = target[ADDR_W-1:0];  empty_in = 1'b0;
            end else begin
               head_in = '0;  empty_in = 1'b1;
            end
            res_success_in = 1'b1;
            res_off_in     = pick_ff[ADDR_W-1:0] + BUSY_HDR[ADDR_W-1:0];
            res_bytes_in   = gsize_ff;
         end
         CMD_F_HDR: begin
            size_we = 1'b1;  size_wa = hdr_ff;  size_wd = rd_size_ff + BUSY_HDR;
            next_wa = hdr_ff;
            if (empty_ff) begin
               next_we = 1'b1;  next_wd = NIL_LINK;
               head_in = hdr_ff;  empty_in = 1'b0;
            end else if (head_ff > hdr_ff) begin
               next_we = 1'b1;  next_wd = {1'b0, head_ff};
               head_in = hdr_ff;
            end else begin
               cur_in   = {1'b0, head_ff};
               steps_in = '0;
            end
         end
         CMD_F_EV: begin
            steps_in = steps_ff + 1'b1;
            if (status.ins) begin
               next_we = 1'b1;  next_wd = {1'b0, hdr_ff};
               sav_in  = nx_node ? rd_next_ff : NIL_LINK;
            end else begin
               cur_in = rd_next_ff;
            end
         end
         CMD_F_LINK2: begin
            next_we = 1'b1;  next_wa = hdr_ff;  next_wd = sav_ff;
         end
         CMD_M_INIT: begin
            cur_in   = head_node;
            steps_in = '0;
         end
         CMD_M_EV: begin
            steps_in = steps_ff + 1'b1;
            if (status.touch) begin
               sav_in  = rd_next_ff;
               csz_in  = rd_size_ff;
               rd_en   = 1'b1;
               rd_addr = rd_next_ff[ADDR_W-1:0];
            end else begin
               cur_in = rd_next_ff;
            end
         end
         CMD_M_EV2: begin
            // absorb the touching neighbor, stay on this node
            size_we = 1'b1;  size_wd = csz_ff + rd_size_ff;
            next_we = 1'b1;  next_wd = rd_next_ff;
         end
         default: begin
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (size_we) size_ram[size_wa] <= size_wd;
      if (next_we) next_ram[next_wa] <= next_wd;
      if (rd_en) begin
         rd_size_ff <= size_ram[rd_addr];
         rd_next_ff <= next_ram[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         policy_ff    <= POL_FIRST;
         head_ff      <= '0;
         empty_ff     <= 1'b0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         head_ff    <= head_in;
         empty_ff   <= empty_in;
         steps_ff   <= steps_in;
         if (csr_valid) policy_ff <= csr_data;
         if (cmd == CMD_LOAD)  rsp_valid_ff <= 1'b1;
         else if (rsp_tready)  rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      pick_ff        <= pick_in;
      pick_prev_ff   <= pick_prev_in;
      cand_ff        <= cand_in;
      gsize_ff       <= gsize_in;
      sav_ff         <= sav_in;
      csz_ff         <= csz_in;
      real_ff        <= real_in;
      hdr_ff         <= hdr_in;
      split_ff       <= split_in;
      res_success_ff <= res_success_in;
      res_off_ff     <= res_off_in;
      res_bytes_ff   <= res_bytes_in;
      if (cmd == CMD_LOAD) begin
         out_success_ff <= res_success_ff;
         out_off_ff     <= res_off_ff;
         out_bytes_ff   <= res_bytes_ff;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_success      = out_success_ff;
   assign rsp_grant_offset = out_off_ff;
   assign rsp_grant_bytes  = out_bytes_ff;

   // a grant is never smaller than the minimum payload
   a_grant_min: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_A_COMMIT |=> res_success_ff && res_bytes_ff >= MIN_PAYLOAD)
      else $error("grant below minimum payload");

   // list walks stay within their step bound
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= STEP_MAX)
      else $error("walk step count beyond bound");

   // no header memory write while idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_NONE || cmd == CMD_LOAD || cmd == CMD_ACCEPT) |-> !size_we && !next_we)
      else $error("memory written outside an operation");

endmodule
